// ----- src/jur_pkg.sv -----
// Shared types and constants for the JTAG UART register model.
`timescale 1ns / 1ps

package jur_pkg;

	// Item command codes
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Register word codes
	localparam logic ADDR_DATA = 1'b0;
	localparam logic ADDR_CTRL = 1'b1;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONSOLE_ENABLED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL   = 2'd1;

	localparam int POLL_W = 14;
	localparam int CFG_DATA_W = POLL_W;
	localparam logic [POLL_W-1:0] POLL_RESET = 14'd10000;

	// Control word layout
	localparam int CTL_RE_POS       = 0;
	localparam int CTL_WE_POS       = 1;
	localparam int CTL_RIRQ_POS     = 8;
	localparam int CTL_WIRQ_POS     = 9;
	localparam int CTL_AC_POS       = 10;
	localparam int CTL_RRDY_POS     = 12;
	localparam int CTL_WSPACE_POS   = 16;
	localparam logic [31:0] WRITE_SPACE = 32'd63;

	// Data word layout
	localparam int DATA_VALID_POS = 15;
	localparam int DATA_COUNT_POS = 16;

endpackage

// ----- src/jur_rx_store.sv -----
// Receive byte store: synchronous memory with a fill mark for unwritten entries.
`timescale 1ns / 1ps

module jur_rx_store #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_byte,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_byte
);

	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

	logic [7:0]    mem_q [DEPTH];
	logic [7:0]    rd_raw_q;
	logic          rd_written_q;
	logic [FW-1:0] fill_q;

	// Writes land at ascending slots from zero, so entries below the fill mark hold data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr_en && fill_q != FILL_MAX) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_written_q <= 1'b0;
		end else if (rd_en) begin
			rd_written_q <= FW'(rd_addr) < fill_q;
		end
	end

	// Write and registered read of the store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_byte;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	// Never-written entries read as their cleared value
	assign rd_byte = rd_written_q ? rd_raw_q : 8'd0;

endmodule

// ----- src/jtag_uart_register_model.sv -----
// Top level of the JTAG UART register model: control state, receive FIFO and result pipeline.
`timescale 1ns / 1ps

// Takes one transaction per clock cycle, every cycle, as long as the result side keeps
// up. An accepted transaction updates the FIFO pointers, poll countdown and flags and
// issues the store read; a holding stage keeps the partial word while the receive
// memory's registered read port completes, and the byte is then merged into the data
// word as it loads the output register. The input side stalls only when both the
// holding stage and the output register are full and the output is stalled. The store
// needs no clearing pass after reset: a fill mark makes unwritten entries read 0.
module jtag_uart_register_model #(
	parameter int RX_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [jur_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [jur_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        cmd,
	input  logic                              addr,
	input  logic [31:0]                       write_data,
	input  logic                              key_valid,
	input  logic [7:0]                        key_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       read_data,
	output logic                              tx_valid,
	output logic [7:0]                        tx_byte
);

	import jur_pkg::*;

	localparam int HW = $clog2(RX_DEPTH);
	localparam int CW = $clog2(RX_DEPTH + 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(RX_DEPTH);
	localparam logic [HW:0]   SLOT_WRAP  = (HW + 1)'(RX_DEPTH);
	localparam logic [HW-1:0] HEAD_LAST  = HW'(RX_DEPTH - 1);

	// Configuration and control state
	logic              console_enabled_q;
	logic [POLL_W-1:0] poll_interval_q;
	logic [HW-1:0]     head_q, head_d;
	logic [CW-1:0]     count_q, count_d;
	logic [POLL_W-1:0] countdown_q, countdown_d;
	logic              rie_q, rie_d;
	logic              wie_q, wie_d;
	logic              activity_q, activity_d;

	// Pipeline
	logic        valid_s1, valid_s2;
	logic [31:0] word_s1, word_d;
	logic        use_byte_s1, use_byte_d;
	logic        tx_valid_s1, tx_valid_d;
	logic [7:0]  tx_byte_s1, tx_byte_d;
	logic [31:0] read_data_s2;
	logic        tx_valid_s2;
	logic [7:0]  tx_byte_s2;

	logic        accept;
	logic        advance;
	logic        push;
	logic        pop;
	logic [HW:0] slot_sum;
	logic [HW-1:0] tail;
	logic [7:0]  store_byte;
	cmd_t        cmd_c;

	assign cmd_c   = cmd_t'(cmd);
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept  = in_valid && !in_stall;

	// Write slot behind the newest queued byte
	assign slot_sum = {1'b0, head_q} + (HW + 1)'(count_q);
	assign tail = (slot_sum >= SLOT_WRAP) ? HW'(slot_sum - SLOT_WRAP) : slot_sum[HW-1:0];

	// Decode the transaction and form the next control state
	always_comb begin
		head_d      = head_q;
		count_d     = count_q;
		countdown_d = countdown_q;
		rie_d       = rie_q;
		wie_d       = wie_q;
		activity_d  = activity_q;
		word_d      = 32'd0;
		use_byte_d  = 1'b0;
		tx_valid_d  = 1'b0;
		tx_byte_d   = 8'd0;
		push        = 1'b0;
		pop         = 1'b0;
		unique case (cmd_c)
			CMD_TICK: begin
				if (console_enabled_q && count_q < COUNT_FULL) begin
					if (countdown_q != '0) begin
						countdown_d = countdown_q - 1'b1;
					end else begin
						countdown_d = poll_interval_q;
						activity_d  = 1'b1;
						if (key_valid) begin
							push    = 1'b1;
							count_d = count_q + 1'b1;
						end
					end
				end
			end
			CMD_READ: begin
				if (addr == ADDR_DATA) begin
					use_byte_d = 1'b1;
					if (count_q != '0) begin
						pop     = 1'b1;
						count_d = count_q - 1'b1;
						head_d  = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
					end
					word_d = (32'(count_d) << DATA_COUNT_POS)
						| (32'(pop) << DATA_VALID_POS);
				end else begin
					word_d = (32'(rie_q) << CTL_RE_POS)
						| (32'(wie_q) << CTL_WE_POS)
						| (32'(rie_q && count_q != '0) << CTL_RIRQ_POS)
						| (32'(wie_q) << CTL_WIRQ_POS)
						| (32'(activity_q) << CTL_AC_POS)
						| (32'(count_q != '0) << CTL_RRDY_POS)
						| (WRITE_SPACE << CTL_WSPACE_POS);
				end
			end
			CMD_WRITE: begin
				if (addr == ADDR_DATA) begin
					tx_valid_d = 1'b1;
					tx_byte_d  = write_data[7:0];
					activity_d = 1'b1;
				end else begin
					rie_d = write_data[CTL_RE_POS];
					wie_d = write_data[CTL_WE_POS];
					if (write_data[CTL_AC_POS]) begin
						activity_d = 1'b0;
					end
				end
			end
			CMD_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_enabled_q <= 1'b0;
			poll_interval_q   <= POLL_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_CONSOLE_ENABLED) begin
				console_enabled_q <= cfg_data[0];
			end else if (cfg_index == CFG_POLL_INTERVAL) begin
				poll_interval_q <= cfg_data[POLL_W-1:0];
			end
		end
	end

	// Commit control state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			countdown_q <= '0;
			rie_q       <= 1'b0;
			wie_q       <= 1'b0;
			activity_q  <= 1'b0;
		end else if (accept) begin
			head_q      <= head_d;
			count_q     <= count_d;
			countdown_q <= countdown_d;
			rie_q       <= rie_d;
			wie_q       <= wie_d;
			activity_q  <= activity_d;
		end
	end

	// Receive store: pushes at the tail, data reads at the head
	jur_rx_store #(
		.DEPTH(RX_DEPTH)
	) u_rx_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && push),
		.wr_addr (tail),
		.wr_byte (key_code),
		.rd_en   (accept && use_byte_d),
		.rd_addr (head_q),
		.rd_byte (store_byte)
	);

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Hold the partial result while the store read completes
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1     <= word_d;
			use_byte_s1 <= use_byte_d;
			tx_valid_s1 <= tx_valid_d;
			tx_byte_s1  <= tx_byte_d;
		end
	end

	// Merge the store byte and load the output register
	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= word_s1 | (use_byte_s1 ? 32'(store_byte) : 32'd0);
			tx_valid_s2  <= tx_valid_s1;
			tx_byte_s2   <= tx_byte_s1;
		end
	end

	assign out_valid = valid_s2;
	assign read_data = read_data_s2;
	assign tx_valid  = tx_valid_s2;
	assign tx_byte   = tx_byte_s2;

endmodule

// ----- verif/tb_jtag_uart_register_model.sv -----
// Self-checking testbench for the JTAG UART register model: directed table, then random phases.
`timescale 1ns / 1ps

module tb_jtag_uart_register_model;
	import jur_pkg::*;

	localparam int FIFO_DEPTH = 64;
	localparam int SETTLE_CYCLES = 4;
	localparam int POST_DRAIN_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	// Indexes that name no register; writes to them must be ignored
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 2'd3;

	typedef struct packed {
		cmd_t        cmd;
		logic        addr;
		logic [31:0] wdata;
		logic        kv;
		logic [7:0]  kc;
	} uart_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        tx_valid;
		logic [7:0]  tx_byte;
	} uart_result_t;

	typedef struct packed {
		logic                   is_cfg;
		logic [CFG_INDEX_W-1:0] cfg_idx;
		logic [CFG_DATA_W-1:0]  cfg_val;
		uart_item_t             item;
		logic                   typed;
		uart_result_t           result;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	cmd_t                   cmd;
	logic                   addr;
	logic [31:0]            write_data;
	logic                   key_valid;
	logic [7:0]             key_code;
	logic                   out_valid;
	logic                   out_stall;
	logic [31:0]            read_data;
	logic                   tx_valid;
	logic [7:0]             tx_byte;

	jtag_uart_register_model #(.RX_DEPTH(FIFO_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.addr(addr),
		.write_data(write_data),
		.key_valid(key_valid),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte)
	);

	// Shadow state of the UART, as after reset
	logic [7:0]        rx_mem [FIFO_DEPTH];
	int                rx_head = 0;
	int                rx_count = 0;
	logic [POLL_W-1:0] poll_left = '0;
	logic              rd_irq_en = 1'b0;
	logic              wr_irq_en = 1'b0;
	logic              activity = 1'b0;
	logic              console_en = 1'b0;
	logic [POLL_W-1:0] poll_interval = POLL_RESET;

	uart_result_t pending_results[$];
	dir_row_t     directed_rows[$];

	int  mismatch_count = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  bytes_queued = 0;
	int  full_ticks = 0;
	int  empty_reads = 0;
	bit  quiet_mode = 1'b0;
	bit  hold_request = 1'b0;

	// Advance the shadow state by one transaction and return its result
	function automatic uart_result_t compute_uart_result(uart_item_t it);
		uart_result_t r;
		logic         present;
		logic [7:0]   rx_byte;
		int           slot;
		r = '0;
		present = (rx_count != 0);
		case (it.cmd)
			CMD_TICK: begin
				if (console_en && rx_count >= FIFO_DEPTH) begin
					full_ticks++;
				end else if (console_en) begin
					if (poll_left != '0) begin
						poll_left--;
					end else begin
						poll_left = poll_interval;
						if (it.kv) begin
							slot = (rx_head + rx_count) % FIFO_DEPTH;
							rx_mem[slot] = it.kc;
							rx_count++;
							bytes_queued++;
						end
						activity = 1'b1;
					end
				end
			end
			CMD_READ: begin
				if (it.addr == ADDR_DATA) begin
					rx_byte = rx_mem[rx_head];
					if (present) begin
						rx_count--;
						rx_head = (rx_head + 1) % FIFO_DEPTH;
					end else begin
						empty_reads++;
					end
					r.read_data[DATA_COUNT_POS +: 16] = 16'(rx_count);
					r.read_data[DATA_VALID_POS] = present;
					r.read_data[7:0] = rx_byte;
				end else begin
					r.read_data[CTL_RE_POS] = rd_irq_en;
					r.read_data[CTL_WE_POS] = wr_irq_en;
					r.read_data[CTL_RIRQ_POS] = rd_irq_en && present;
					r.read_data[CTL_WIRQ_POS] = wr_irq_en;
					r.read_data[CTL_AC_POS] = activity;
					r.read_data[CTL_RRDY_POS] = present;
					r.read_data = r.read_data | (WRITE_SPACE << CTL_WSPACE_POS);
				end
			end
			CMD_WRITE: begin
				if (it.addr == ADDR_DATA) begin
					r.tx_valid = 1'b1;
					r.tx_byte = it.wdata[7:0];
					activity = 1'b1;
				end else begin
					rd_irq_en = it.wdata[CTL_RE_POS];
					wr_irq_en = it.wdata[CTL_WE_POS];
					if (it.wdata[CTL_AC_POS])
						activity = 1'b0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic uart_item_t random_uart_item(int tick_pct, int key_pct);
		uart_item_t it;
		int         roll;
		it.addr = 1'($urandom_range(0, 1));
		it.wdata = $urandom;
		it.kv = ($urandom_range(0, 99) < key_pct);
		it.kc = 8'($urandom_range(0, 255));
		roll = $urandom_range(0, 19);
		if ($urandom_range(0, 99) < tick_pct)
			it.cmd = CMD_TICK;
		else if (roll == 0)
			it.cmd = CMD_NOP;
		else if (roll <= 10)
			it.cmd = CMD_READ;
		else
			it.cmd = CMD_WRITE;
		return it;
	endfunction

	task automatic add_item_row(input cmd_t c, input logic a, input logic [31:0] wd,
			input logic kv, input logic [7:0] kc, input logic typed,
			input logic [31:0] rd, input logic txv, input logic [7:0] txb);
		dir_row_t row;
		row = '0;
		row.item = '{cmd: c, addr: a, wdata: wd, kv: kv, kc: kc};
		row.typed = typed;
		row.result = '{read_data: rd, tx_valid: txv, tx_byte: txb};
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = val;
		directed_rows.push_back(row);
	endtask

	// Offer one transaction, hold it until accepted, then record what it should produce
	task automatic send_uart_item(input uart_item_t it, input logic typed,
			input uart_result_t typed_result);
		uart_result_t predicted;
		int           gap;
		gap = 0;
		if (!quiet_mode && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		addr <= it.addr;
		write_data <= it.wdata;
		key_valid <= it.kv;
		key_code <= it.kc;
		do @(posedge clk); while (in_stall);
		predicted = compute_uart_result(it);
		pending_results.push_back(typed ? typed_result : predicted);
		items_sent++;
	endtask

	// Stop offering and wait until every expected result is back, then let the pipe settle
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_results_drained();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_CONSOLE_ENABLED: console_en = val[0];
			CFG_POLL_INTERVAL:   poll_interval = val;
			default: ;
		endcase
	endtask

	task automatic run_random_phase(input logic en, input logic [POLL_W-1:0] interval,
			input int n_items, input int tick_pct, input int key_pct, input int hold_at);
		uart_result_t none;
		none = '0;
		write_register(CFG_CONSOLE_ENABLED, {13'($urandom), en});
		write_register(CFG_POLL_INTERVAL, interval);
		if ($urandom_range(0, 1) == 1)
			write_register($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
				14'($urandom));
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			send_uart_item(random_uart_item(tick_pct, key_pct), 1'b0, none);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin : result_side
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		uart_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: read_data %h tx_valid %b tx_byte %h",
					read_data, tx_valid, tx_byte);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, read_data);
					mismatch_count++;
				end
				if (tx_valid !== want.tx_valid) begin
					$error("tx_valid: expected %b, got %b", want.tx_valid, tx_valid);
					mismatch_count++;
				end
				if (tx_byte !== want.tx_byte) begin
					$error("tx_byte: expected %h, got %h", want.tx_byte, tx_byte);
					mismatch_count++;
				end
			end
		end
	end

	// End the run if nothing moves on either side for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		dir_row_t row;
		for (int i = 0; i < FIFO_DEPTH; i++)
			rx_mem[i] = 8'h00;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_CONSOLE_ENABLED;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_NOP;
		addr <= ADDR_DATA;
		write_data <= '0;
		key_valid <= 1'b0;
		key_code <= '0;

		// Directed table: reset values, extremes, every command and the corner cases
		add_item_row(CMD_READ,  ADDR_CTRL, 32'h0000_0000, 0, 8'h00, 1, 32'h003F_0000, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_DATA, 32'h0000_0000, 0, 8'h00, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_TICK,  ADDR_DATA, 32'h0000_0000, 1, 8'hFF, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_NOP,   ADDR_CTRL, 32'hFFFF_FFFF, 1, 8'hFF, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_WRITE, ADDR_DATA, 32'hFFFF_FFFF, 0, 8'h00, 1, 32'h0000_0000, 1, 8'hFF);
		add_item_row(CMD_READ,  ADDR_CTRL, 32'h0000_0000, 0, 8'h00, 1, 32'h003F_0400, 0, 8'h00);
		add_item_row(CMD_WRITE, ADDR_CTRL, 32'h0000_0403, 0, 8'h00, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_CTRL, 32'h0000_0000, 0, 8'h00, 1, 32'h003F_0203, 0, 8'h00);
		add_item_row(CMD_WRITE, ADDR_DATA, 32'h0000_0000, 0, 8'h00, 1, 32'h0000_0000, 1, 8'h00);
		add_cfg_row(CFG_CONSOLE_ENABLED, 14'h0001);
		add_cfg_row(CFG_POLL_INTERVAL, 14'h0000);
		add_cfg_row(CFG_UNUSED_LO, 14'h3FFF);
		add_cfg_row(CFG_UNUSED_HI, 14'h0000);
		add_item_row(CMD_TICK,  ADDR_DATA, 32'h0000_0000, 1, 8'hA5, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_TICK,  ADDR_CTRL, 32'h0000_0000, 0, 8'h3C, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_TICK,  ADDR_DATA, 32'h0000_0000, 1, 8'h00, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_TICK,  ADDR_DATA, 32'h0000_0000, 1, 8'hFF, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_CTRL, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_DATA, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_DATA, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_DATA, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_DATA, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);
		add_cfg_row(CFG_POLL_INTERVAL, 14'h3FFF);
		add_item_row(CMD_TICK,  ADDR_DATA, 32'h0000_0000, 1, 8'h5A, 0, '0, 0, 8'h00);
		add_item_row(CMD_TICK,  ADDR_DATA, 32'h0000_0000, 1, 8'h11, 0, '0, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_DATA, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);
		add_item_row(CMD_WRITE, ADDR_CTRL, 32'hFFFF_FFFF, 0, 8'h00, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_CTRL, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);
		add_item_row(CMD_WRITE, ADDR_CTRL, 32'h0000_0000, 0, 8'h00, 1, 32'h0000_0000, 0, 8'h00);
		add_item_row(CMD_READ,  ADDR_CTRL, 32'h0000_0000, 0, 8'h00, 0, '0, 0, 8'h00);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Walk the directed table
		for (int i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.is_cfg)
				write_register(row.cfg_idx, row.cfg_val);
			else
				send_uart_item(row.item, row.typed, row.result);
		end

		// Random phases: fill to full, mixed with a long hold-off, console off,
		// longest poll interval, drain-heavy, then a final stretch with no idling
		run_random_phase(1'b1, 14'd0, 120, 80, 90, -1);
		run_random_phase(1'b1, 14'($urandom_range(1, 3)), 150, 40, 70, 30);
		run_random_phase(1'b0, 14'($urandom), 60, 50, 50, -1);
		run_random_phase(1'b1, 14'h3FFF, 50, 60, 80, -1);
		run_random_phase(1'b1, 14'd0, 100, 20, 80, -1);
		quiet_mode = 1'b1;
		run_random_phase(1'b1, 14'd0, 120, 50, 80, -1);

		wait_results_drained();
		repeat (POST_DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d transactions, %0d results checked, %0d mismatches",
			items_sent, results_checked, mismatch_count);
		$display("fifo: %0d bytes queued, %0d ticks while full, %0d reads while empty",
			bytes_queued, full_ticks, empty_reads);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
